FILE: rtl/core/reassembly_context_table_macros.svh
// Assertion macros for the reassembly context table checker.
`ifndef REASSEMBLY_CONTEXT_TABLE_MACROS_SVH
`define REASSEMBLY_CONTEXT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("reassembly context table check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("reassembly context table check failed");

`endif

FILE: rtl/core/rct_pkg.sv
// Shared types and constants of the reassembly context table.
package rct_pkg;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 32;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // configuration register index (paddr[2])
  localparam logic REG_TIMEOUT = 1'b0;

  // input action codes
  localparam logic ACT_LOOKUP  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_HIT       = 3'd0;
  localparam logic [2:0] STAT_ALLOC     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_RELEASED  = 3'd3;
  localparam logic [2:0] STAT_NOT_VALID = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } rct_state_t;

  typedef struct packed {
    logic start;   // latch item, clear scan results
    logic issue;   // read next entry
    logic commit;  // update table, load result
  } rct_cmd_t;

  typedef struct packed {
    logic is_release;   // action bit of the offered item
    logic last_issued;  // read address is at the last entry
    logic out_free;     // result register can take a new result
  } rct_sts_t;

endpackage

FILE: rtl/core/rct_cfg.sv
// APB-style register block holding the idle timeout.
module rct_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [rct_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [rct_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rct_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output logic [31:0]               timeout
);
  import rct_pkg::*;

  logic [31:0] timeout_r;
  logic [31:0] timeout_nxt;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    timeout_nxt = timeout_r;
    if (wr_en && (cfg_paddr[2] == REG_TIMEOUT)) begin
      timeout_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_TIMEOUT: cfg_prdata = timeout_r;
      default:     cfg_prdata = '0;
    endcase
  end

  assign timeout = timeout_r;

endmodule

FILE: rtl/core/rct_ctrl.sv
// Sequencer: accept, scan the table, drain the read pipe, commit; a release skips scan and drain.
module rct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rct_pkg::rct_sts_t sts,
  output rct_pkg::rct_cmd_t cmd
);
  import rct_pkg::*;

  rct_state_t state_r;
  rct_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.is_release ? S_COMMIT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.last_issued) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.start = in_tvalid;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/rct_dp.sv
// Datapath: context memory, valid bits, scan evaluation and result register.
module rct_dp #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rct_pkg::rct_cmd_t            cmd,
  output rct_pkg::rct_sts_t            sts,
  input  logic [rct_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                         in_tuser,
  input  logic [31:0]                  timeout,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [rct_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [2:0]                   out_tuser
);
  import rct_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // latched item
  logic              action_r;
  logic [31:0]       key_r;
  logic [31:0]       now_r;
  logic [2:0]        rel_r;

  // context memory: {id, stamp}
  logic [63:0]       ctx_mem_r [ENTRIES];
  logic [63:0]       rdata_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;

  // scan pipe
  logic [IDX_W-1:0]  addr_r,  addr_nxt;
  logic [IDX_W-1:0]  rd_idx_r;
  logic              rd_vld_r, rd_vld_nxt;

  // scan results
  logic              hit_found_r,  hit_found_nxt;
  logic [IDX_W-1:0]  hit_idx_r,    hit_idx_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IDX_W-1:0]  free_idx_r,   free_idx_nxt;
  logic [ENTRIES-1:0] exp_vec_r,   exp_vec_nxt;
  logic [CNT_W-1:0]  exp_cnt_r,    exp_cnt_nxt;

  logic [ENTRIES-1:0] valid_r,     valid_nxt;

  // result register
  logic              out_valid_r,  out_valid_nxt;
  logic [2:0]        out_stat_r,   out_stat_nxt;
  logic [2:0]        out_slot_r,   out_slot_nxt;
  logic [3:0]        out_evict_r,  out_evict_nxt;

  // evaluation of the entry read last cycle
  logic              ev_valid;
  logic              ev_match;
  logic              ev_exp;
  logic              ev_free;
  logic [31:0]       ev_age;
  logic [ENTRIES-1:0] rel_sel;
  logic [ENTRIES-1:0] alloc_sel;
  logic [3:0]        evict_sat;

  assign ev_valid = valid_r[rd_idx_r];
  assign ev_age   = now_r - rdata_r[31:0];
  assign ev_match = ev_valid && (rdata_r[63:32] == key_r);
  assign ev_exp   = ev_valid && (ev_age > timeout);
  assign ev_free  = !ev_valid || ev_exp;

  assign evict_sat = (32'(exp_cnt_r) > 32'd15) ? 4'd15 : 4'(exp_cnt_r);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rel_sel[i]   = (i < 8) && (rel_r == 3'(i));
      alloc_sel[i] = (free_idx_r == IDX_W'(i));
    end
  end

  assign sts.is_release  = (in_tuser == ACT_RELEASE);
  assign sts.last_issued = (addr_r == LAST_IDX);
  assign sts.out_free    = !out_valid_r || out_tready;

  assign mem_we = cmd.commit && (action_r == ACT_LOOKUP) && (hit_found_r || free_found_r);
  assign mem_wa = hit_found_r ? hit_idx_r : free_idx_r;

  always_comb begin
    addr_nxt       = addr_r;
    rd_vld_nxt     = cmd.issue;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    exp_vec_nxt    = exp_vec_r;
    exp_cnt_nxt    = exp_cnt_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_stat_nxt   = out_stat_r;
    out_slot_nxt   = out_slot_r;
    out_evict_nxt  = out_evict_r;

    if (cmd.start) begin
      addr_nxt       = '0;
      hit_found_nxt  = 1'b0;
      hit_idx_nxt    = '0;
      free_found_nxt = 1'b0;
      free_idx_nxt   = '0;
      exp_vec_nxt    = '0;
      exp_cnt_nxt    = '0;
    end

    if (cmd.issue && !sts.last_issued) begin
      addr_nxt = addr_r + IDX_W'(1);
    end

    if (rd_vld_r) begin
      if (ev_match && !hit_found_r) begin
        hit_found_nxt = 1'b1;
        hit_idx_nxt   = rd_idx_r;
      end
      if (ev_exp) begin
        exp_vec_nxt[rd_idx_r] = 1'b1;
        exp_cnt_nxt           = exp_cnt_r + CNT_W'(1);
      end
      if (ev_free && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_idx_nxt   = rd_idx_r;
      end
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      if (action_r == ACT_RELEASE) begin
        out_slot_nxt  = rel_r;
        out_evict_nxt = 4'd0;
        if (|(valid_r & rel_sel)) begin
          valid_nxt    = valid_r & ~rel_sel;
          out_stat_nxt = STAT_RELEASED;
        end else begin
          out_stat_nxt = STAT_NOT_VALID;
        end
      end else if (hit_found_r) begin
        out_stat_nxt  = STAT_HIT;
        out_slot_nxt  = 3'(hit_idx_r);
        out_evict_nxt = 4'd0;
      end else if (free_found_r) begin
        valid_nxt     = (valid_r & ~exp_vec_r) | alloc_sel;
        out_stat_nxt  = STAT_ALLOC;
        out_slot_nxt  = 3'(free_idx_r);
        out_evict_nxt = evict_sat;
      end else begin
        // no free slot means nothing expired either
        valid_nxt     = valid_r & ~exp_vec_r;
        out_stat_nxt  = STAT_FULL;
        out_slot_nxt  = 3'd0;
        out_evict_nxt = evict_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r <= in_tuser;
      key_r    <= in_tdata[31:0];
      now_r    <= in_tdata[63:32];
      rel_r    <= in_tdata[66:64];
    end
    if (mem_we) begin
      ctx_mem_r[mem_wa] <= {key_r, now_r};
    end
    if (cmd.issue) begin
      rdata_r  <= ctx_mem_r[addr_r];
      rd_idx_r <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      hit_idx_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      exp_vec_r    <= '0;
      exp_cnt_r    <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      addr_r       <= addr_nxt;
      rd_vld_r     <= rd_vld_nxt;
      hit_found_r  <= hit_found_nxt;
      hit_idx_r    <= hit_idx_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      exp_vec_r    <= exp_vec_nxt;
      exp_cnt_r    <= exp_cnt_nxt;
      valid_r      <= valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_stat_r  <= out_stat_nxt;
    out_slot_r  <= out_slot_nxt;
    out_evict_r <= out_evict_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tdata  = {1'b0, out_evict_r, out_slot_r};

endmodule

FILE: rtl/core/reassembly_context_table.sv
// Top level of the reassembly context table with idle timeout.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  in_     | slave     | in_tvalid/in_tready   | tuser: action; tdata: key, now, slot
//  out_    | master    | out_tvalid/out_tready | tuser: status; tdata: slot, evicted
//  cfg_    | APB slave | psel/penable, pready=1| reg 0 @ 0x0: timeout_ms
//
// Lookup: after accept, the scan reads one entry per cycle over the single read
//   port of the context memory, then the DRAIN and COMMIT states follow.
// Release: goes from accept straight to COMMIT; no memory access.
// One item in flight; a held result stalls only the commit, not the accept.
// Reset (sync, active low) clears the valid bits and control; no clearing pass.
module reassembly_context_table #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rct_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] key_id, [63:32] now_ms,
                                                     // [66:64] release_slot, rest 0
  input  logic                          in_tuser,   // [0] action
  // result items
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rct_pkg::OUT_DATA_W-1:0] out_tdata,  // [2:0] slot_index,
                                                     // [6:3] evicted_count, [7] 0
  output logic [2:0]                    out_tuser,  // [2:0] status
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rct_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [rct_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [rct_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                          cfg_pready
);
  import rct_pkg::*;

  rct_cmd_t    cmd;
  rct_sts_t    sts;
  logic [31:0] timeout;

  // timeout register
  rct_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .timeout     (timeout)
  );

  // sequencer: IDLE -> SCAN (ENTRIES reads) -> DRAIN -> COMMIT, release skips scan and drain
  rct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // scan collects first hit, first free-or-expired slot and the expired set;
  // commit then applies hit refresh, eviction plus allocation, or the release of a slot
  rct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .timeout    (timeout),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/rct_checker.sv
// Port-level checker for the reassembly context table, with its bind.
`include "reassembly_context_table_macros.svh"

module rct_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [rct_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [2:0]                    out_tuser
);
  import rct_pkg::*;

  logic       in_acc;
  logic       out_stall;
  logic       out_full;
  logic       out_quiet;
  logic [2:0] out_slot;
  logic [3:0] out_evict;

  assign in_acc    = in_tvalid && in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_full  = out_tvalid && (out_tuser == STAT_FULL);
  assign out_quiet = out_tvalid && ((out_tuser == STAT_HIT) || (out_tuser == STAT_RELEASED) ||
                                    (out_tuser == STAT_NOT_VALID));
  assign out_slot  = out_tdata[2:0];
  assign out_evict = out_tdata[6:3];

  // a stalled result holds
  `RCT_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // one item at a time: busy right after an accept
  `RCT_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_tready)

  // full table reports slot zero
  `RCT_ASSERT_NOW(a_full_slot_zero, out_full, out_slot == 3'd0)

  // only a lookup miss may evict
  `RCT_ASSERT_NOW(a_no_evict_outside_miss, out_quiet, out_evict == 4'd0)

endmodule

bind reassembly_context_table rct_checker u_rct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
